FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/blg_pkg.sv
// ----------------------------------------------------------------------------
// blg_pkg
// Command codes and the control word passed from the front end to the step
// engine of the line generator.
// ----------------------------------------------------------------------------
package blg_pkg;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } blg_cmd_t;

    typedef struct packed {
        blg_cmd_t cmd;
        logic     steep;
        logic     down;
        logic     live;
    } blg_ctrl_t;

    localparam int unsigned CTRL_W = $bits(blg_ctrl_t);

endpackage

FILE: hw/rtl/blg_front.sv
// ----------------------------------------------------------------------------
// blg_front
// Input side: accepts commands and reduces a start command to major/minor
// axis form, ready for the step engine.
// ----------------------------------------------------------------------------
module blg_front
    import blg_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned IN_DATA_W  = 72
)
(
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,    // start_x, start_y, end_x, end_y, line_color
    input  logic                    s_tuser,    // command
    input  logic                    q_full,
    output logic                    q_push,
    output blg_ctrl_t               q_ctrl,
    output logic [COORD_BITS-1:0]   q_major_pos,
    output logic [COORD_BITS-1:0]   q_major_end,
    output logic [COORD_BITS-1:0]   q_minor_pos,
    output logic [COORD_BITS-1:0]   q_major_delta,
    output logic [COORD_BITS-1:0]   q_minor_delta,
    output logic [23:0]             q_color
);

    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
    logic                  x_gt;
    logic                  x_lt;
    logic                  y_gt;
    logic                  y_lt;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  steep;
    logic                  swap;
    logic [COORD_BITS-1:0] ma;
    logic [COORD_BITS-1:0] mb;
    logic [COORD_BITS-1:0] na;
    logic [COORD_BITS-1:0] nb;

    assign ax = s_tdata[COORD_BITS-1:0];
    assign ay = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign bx = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign by = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        x_gt  = ax > bx;
        x_lt  = ax < bx;
        y_gt  = ay > by;
        y_lt  = ay < by;
        dx    = x_gt ? (ax - bx) : (bx - ax);
        dy    = y_gt ? (ay - by) : (by - ay);
        steep = dx < dy;
        ma    = steep ? ay : ax;
        mb    = steep ? by : bx;
        na    = steep ? ax : ay;
        nb    = steep ? bx : by;
        swap  = steep ? y_gt : x_gt;

        q_major_pos   = swap ? mb : ma;
        q_major_end   = swap ? ma : mb;
        q_minor_pos   = swap ? nb : na;
        q_major_delta = steep ? dy : dx;
        q_minor_delta = steep ? dx : dy;
        q_color       = s_tdata[4*COORD_BITS+23:4*COORD_BITS];

        q_ctrl.cmd   = blg_cmd_t'(s_tuser);
        q_ctrl.steep = steep;
        q_ctrl.down  = swap ? (steep ? x_lt : y_lt) : (steep ? x_gt : y_gt);
        q_ctrl.live  = q_major_delta != '0;
    end

endmodule

FILE: hw/rtl/blg_fifo.sv
// ----------------------------------------------------------------------------
// blg_fifo
// Short register queue between the front end and the step engine.
// ----------------------------------------------------------------------------
module blg_fifo
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = count_reg == FULL_CNT;
    assign not_empty = count_reg != '0;
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/blg_back.sv
// ----------------------------------------------------------------------------
// blg_back
// Step engine: loads a decoded line, walks it one pixel per step command and
// holds each pixel in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blg_back
    import blg_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned OUT_DATA_W = 48
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_pop,
    input  blg_ctrl_t               q_ctrl,
    input  logic [COORD_BITS-1:0]   q_major_pos,
    input  logic [COORD_BITS-1:0]   q_major_end,
    input  logic [COORD_BITS-1:0]   q_minor_pos,
    input  logic [COORD_BITS-1:0]   q_major_delta,
    input  logic [COORD_BITS-1:0]   q_minor_delta,
    input  logic [23:0]             q_color,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,    // pixel_x, pixel_y, pixel_color
    output logic                    m_tlast     // last_pixel
);

    localparam int unsigned ERR_W = COORD_BITS + 3;

    logic                         active_reg;
    logic                         active_next;
    logic                         steep_reg;
    logic                         steep_next;
    logic                         down_reg;
    logic                         down_next;
    logic [COORD_BITS-1:0]        major_pos_reg;
    logic [COORD_BITS-1:0]        major_pos_next;
    logic [COORD_BITS-1:0]        major_end_reg;
    logic [COORD_BITS-1:0]        major_end_next;
    logic [COORD_BITS-1:0]        minor_pos_reg;
    logic [COORD_BITS-1:0]        minor_pos_next;
    logic [COORD_BITS-1:0]        major_delta_reg;
    logic [COORD_BITS-1:0]        major_delta_next;
    logic [COORD_BITS-1:0]        minor_delta_reg;
    logic [COORD_BITS-1:0]        minor_delta_next;
    logic signed [ERR_W-1:0]      err_reg;
    logic signed [ERR_W-1:0]      err_next;
    logic [23:0]                  color_reg;
    logic [23:0]                  color_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [COORD_BITS-1:0]        px_reg;
    logic [COORD_BITS-1:0]        px_next;
    logic [COORD_BITS-1:0]        py_reg;
    logic [COORD_BITS-1:0]        py_next;
    logic [23:0]                  pcolor_reg;
    logic [23:0]                  pcolor_next;
    logic                         plast_reg;
    logic                         plast_next;

    logic                         out_free;
    logic                         is_start;
    logic                         emit;
    logic                         at_last;
    logic signed [ERR_W-1:0]      twice_minor;
    logic signed [ERR_W-1:0]      major_s;
    logic signed [ERR_W-1:0]      twice_major;
    logic signed [ERR_W-1:0]      err_sum;

    assign out_free    = !out_valid_reg || m_tready;
    assign is_start    = q_ctrl.cmd == CMD_START;
    assign q_pop       = q_valid && (is_start || !active_reg || out_free);
    assign emit        = q_pop && !is_start && active_reg;
    assign at_last     = major_pos_reg == major_end_reg;
    assign twice_minor = signed'(ERR_W'({minor_delta_reg, 1'b0}));
    assign major_s     = signed'(ERR_W'(major_delta_reg));
    assign twice_major = signed'(ERR_W'({major_delta_reg, 1'b0}));
    assign err_sum     = err_reg + twice_minor;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({pcolor_reg, py_reg, px_reg});
    assign m_tlast  = plast_reg;

    always_comb
    begin
        active_next      = active_reg;
        steep_next       = steep_reg;
        down_next        = down_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        err_next         = err_reg;
        color_next       = color_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        px_next          = px_reg;
        py_next          = py_reg;
        pcolor_next      = pcolor_reg;
        plast_next       = plast_reg;

        if (q_pop && is_start)
        begin
            active_next      = q_ctrl.live;
            steep_next       = q_ctrl.steep;
            down_next        = q_ctrl.down;
            major_pos_next   = q_major_pos;
            major_end_next   = q_major_end;
            minor_pos_next   = q_minor_pos;
            major_delta_next = q_major_delta;
            minor_delta_next = q_minor_delta;
            err_next         = '0;
            color_next       = q_color;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            px_next        = steep_reg ? minor_pos_reg : major_pos_reg;
            py_next        = steep_reg ? major_pos_reg : minor_pos_reg;
            pcolor_next    = color_reg;
            plast_next     = at_last;
            major_pos_next = major_pos_reg + 1'b1;
            if (err_sum > major_s)
            begin
                err_next       = err_sum - twice_major;
                minor_pos_next = down_reg ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;
            end
            else
            begin
                err_next = err_sum;
            end
            if (at_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steep_reg       <= steep_next;
        down_reg        <= down_next;
        major_pos_reg   <= major_pos_next;
        major_end_reg   <= major_end_next;
        minor_pos_reg   <= minor_pos_next;
        major_delta_reg <= major_delta_next;
        minor_delta_reg <= minor_delta_next;
        err_reg         <= err_next;
        color_reg       <= color_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        pcolor_reg      <= pcolor_next;
        plast_reg       <= plast_next;
    end

    `ASSERT_IMPLIES(a_err_bounds, active_reg, (err_reg <= major_s) && (err_reg > -major_s), "error term out of range")
    `ASSERT_IMPLIES(a_pos_before_end, active_reg, major_pos_reg <= major_end_reg, "major position passed line end")
    `ASSERT_NEXT(a_last_ends_line, emit && at_last, !active_reg && m_tvalid && m_tlast, "line still active after last pixel")

endmodule

FILE: hw/rtl/bresenham_line_generator.sv
// ----------------------------------------------------------------------------
// bresenham_line_generator
// Integer line rasterizer: a start command loads two endpoints and a color,
// each step command then yields the next pixel of the line.
//
// Input stream s_*: tuser is the command (start or step), tdata carries the
// two endpoints and the color; a step ignores tdata. Output stream m_*: one
// pixel per step while a line is active, tlast marks its final pixel. A start
// never yields a pixel, a step with no active line is dropped, and a start
// with equal endpoints leaves no line active.
// An accepted step enters the queue and its pixel is then registered in
// the output register behind m_tvalid. The front end decodes into a
// two-entry queue and the step engine updates the error term per pixel,
// so while m_tready is high the block sustains one command per clock in
// both directions. When the receiver holds m_tready low, the pixel waits
// in the output register and s_tready falls once the queue is full.
// Reset clears the queue, the output register and the active line.
// ----------------------------------------------------------------------------
module bresenham_line_generator
    import blg_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((4*COORD_BITS+24+7)/8)*8-1:0] s_tdata, // start_x, start_y, end_x, end_y, line_color
    input  logic                  s_tuser,    // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((2*COORD_BITS+24+7)/8)*8-1:0] m_tdata, // pixel_x, pixel_y, pixel_color
    output logic                  m_tlast     // last_pixel
);

    localparam int unsigned IN_DATA_W  = ((4*COORD_BITS + 24 + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W = ((2*COORD_BITS + 24 + 7) / 8) * 8;
    localparam int unsigned ENTRY_W    = CTRL_W + 5*COORD_BITS + 24;
    localparam int unsigned Q_DEPTH    = 2;

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    blg_ctrl_t             f_ctrl;
    logic [COORD_BITS-1:0] f_major_pos;
    logic [COORD_BITS-1:0] f_major_end;
    logic [COORD_BITS-1:0] f_minor_pos;
    logic [COORD_BITS-1:0] f_major_delta;
    logic [COORD_BITS-1:0] f_minor_delta;
    logic [23:0]           f_color;
    logic [ENTRY_W-1:0]    push_word;
    logic [ENTRY_W-1:0]    head_word;
    blg_ctrl_t             h_ctrl;
    logic [COORD_BITS-1:0] h_major_pos;
    logic [COORD_BITS-1:0] h_major_end;
    logic [COORD_BITS-1:0] h_minor_pos;
    logic [COORD_BITS-1:0] h_major_delta;
    logic [COORD_BITS-1:0] h_minor_delta;
    logic [23:0]           h_color;

    blg_front #(
        .COORD_BITS (COORD_BITS),
        .IN_DATA_W  (IN_DATA_W)
    ) u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_ctrl        (f_ctrl),
        .q_major_pos   (f_major_pos),
        .q_major_end   (f_major_end),
        .q_minor_pos   (f_minor_pos),
        .q_major_delta (f_major_delta),
        .q_minor_delta (f_minor_delta),
        .q_color       (f_color)
    );

    assign push_word = {f_ctrl, f_color, f_minor_delta, f_major_delta,
                        f_minor_pos, f_major_end, f_major_pos};

    blg_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_data (head_word)
    );

    assign {h_ctrl, h_color, h_minor_delta, h_major_delta,
            h_minor_pos, h_major_end, h_major_pos} = head_word;

    blg_back #(
        .COORD_BITS (COORD_BITS),
        .OUT_DATA_W (OUT_DATA_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_ctrl        (h_ctrl),
        .q_major_pos   (h_major_pos),
        .q_major_end   (h_major_end),
        .q_minor_pos   (h_minor_pos),
        .q_major_delta (h_major_delta),
        .q_minor_delta (h_minor_delta),
        .q_color       (h_color),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule
